// ===== hw/rtl/spp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak picker package
// Shared widths, register map, reset values and record types.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int FFT_POINTS_DEF = 4096;

  localparam int BIN_W   = 12;
  localparam int POWER_W = 32;
  localparam int FREQ_W  = 19;
  localparam int PEAK_W  = 7;
  localparam int RATE_W  = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [BIN_W-1:0]  BIN_MAX  = {BIN_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REG_LOWEST  = 3'd0;
  localparam logic [2:0] REG_HIGHEST = 3'd1;
  localparam logic [2:0] REG_SPACING = 3'd2;
  localparam logic [2:0] REG_MAXPK   = 3'd3;
  localparam logic [2:0] REG_RATE    = 3'd4;

  localparam logic [BIN_W-1:0]  LOWEST_RST  = 12'd1;
  localparam logic [BIN_W-1:0]  HIGHEST_RST = 12'd1024;
  localparam logic [BIN_W-1:0]  SPACING_RST = 12'd3;
  localparam logic [PEAK_W-1:0] MAXPK_RST   = 7'd8;
  localparam logic [RATE_W-1:0] RATE_RST    = 20'd20000;

  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [BIN_W-1:0]  lowest_bin;
    logic [BIN_W-1:0]  highest_bin;
    logic [BIN_W-1:0]  min_spacing;
    logic [PEAK_W-1:0] peak_limit;
    logic [RATE_W-1:0] sample_rate_hz;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [BIN_W-1:0]   bin_index;
    logic [POWER_W-1:0] bin_power;
    logic [PEAK_W-1:0]  peak_number;
    logic               final_item;
  } res_t;

endpackage

// ===== hw/rtl/spp_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak picker configuration registers
// APB-style register file holding the search window, spacing, limit and rate.
// ----------------------------------------------------------------------------
module spp_regs
  import spp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lowest_bin     <= LOWEST_RST;
      cfg.highest_bin    <= HIGHEST_RST;
      cfg.min_spacing    <= SPACING_RST;
      cfg.peak_limit     <= MAXPK_RST;
      cfg.sample_rate_hz <= RATE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOWEST:  cfg.lowest_bin     <= pwdata[BIN_W-1:0];
        REG_HIGHEST: cfg.highest_bin    <= pwdata[BIN_W-1:0];
        REG_SPACING: cfg.min_spacing    <= pwdata[BIN_W-1:0];
        REG_MAXPK:   cfg.peak_limit     <= pwdata[PEAK_W-1:0];
        REG_RATE:    cfg.sample_rate_hz <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOWEST:  prdata = DATA_W'(cfg.lowest_bin);
      REG_HIGHEST: prdata = DATA_W'(cfg.highest_bin);
      REG_SPACING: prdata = DATA_W'(cfg.min_spacing);
      REG_MAXPK:   prdata = DATA_W'(cfg.peak_limit);
      REG_RATE:    prdata = DATA_W'(cfg.sample_rate_hz);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/spp_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak picker detector
// Input register, three-bin window, peak test, strongest-bin search.
// ----------------------------------------------------------------------------
module spp_detect
  import spp_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [POWER_W-1:0] s_tdata,   // power[31:0]
  input  logic               s_tlast,
  input  logic               room,
  output logic [1:0]         push_cnt,
  output res_t               push_a,
  output res_t               push_b
);

  localparam int NYQ_M1 = FFT_POINTS / 2 - 1;

  logic               st_valid;
  logic [POWER_W-1:0] st_power;
  logic               st_last;
  logic               go;

  logic [BIN_W-1:0]   bin_counter;
  logic [POWER_W-1:0] previous_power;
  logic [POWER_W-1:0] center_power;
  logic [BIN_W-1:0]   last_peak_position;
  logic               have_peak;
  logic [PEAK_W-1:0]  peaks_found;
  logic [POWER_W-1:0] best_power;
  logic [BIN_W-1:0]   best_bin;

  logic [POWER_W-1:0] best_power_next;
  logic [BIN_W-1:0]   best_bin_next;
  logic [POWER_W-1:0] best_power_cur;
  logic [BIN_W-1:0]   best_bin_cur;
  logic [BIN_W-1:0]   center_bin;
  logic [BIN_W-1:0]   win_lo;
  logic [BIN_W-1:0]   win_hi;
  logic [BIN_W-1:0]   spacing;
  logic               is_peak;
  logic [PEAK_W-1:0]  peaks_found_next;
  res_t               peak_res;
  res_t               sum_res;

  assign go       = st_valid && room;
  assign s_tready = !st_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_tready) begin
      st_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      st_power <= s_tdata;
      st_last  <= s_tlast;
    end
  end

  always_comb begin
    best_power_cur = (bin_counter == '0) ? '0 : best_power;
    best_bin_cur   = (bin_counter == '0) ? cfg.lowest_bin : best_bin;
    center_bin     = bin_counter - BIN_W'(1);
    win_lo         = (cfg.lowest_bin == '0) ? BIN_W'(1) : cfg.lowest_bin;
    win_hi         = (32'(cfg.highest_bin) > 32'(NYQ_M1)) ? BIN_W'(NYQ_M1) : cfg.highest_bin;
    spacing        = center_bin - last_peak_position;

    is_peak = (bin_counter != '0) && (win_lo < win_hi) &&
              (center_bin >= win_lo) && (center_bin <= win_hi) &&
              (center_power >= previous_power) && (center_power > st_power) &&
              (peaks_found < cfg.peak_limit) &&
              !(have_peak && (spacing < cfg.min_spacing));

    peaks_found_next = peaks_found + PEAK_W'(is_peak);

    if ((bin_counter >= cfg.lowest_bin) && (bin_counter <= cfg.highest_bin) &&
        (st_power > best_power_cur)) begin
      best_power_next = st_power;
      best_bin_next   = bin_counter;
    end else begin
      best_power_next = best_power_cur;
      best_bin_next   = best_bin_cur;
    end

    peak_res.kind        = KIND_PEAK;
    peak_res.bin_index   = center_bin;
    peak_res.bin_power   = center_power;
    peak_res.peak_number = peaks_found;
    peak_res.final_item  = 1'b0;

    sum_res.kind        = KIND_SUMMARY;
    sum_res.bin_index   = best_bin_next;
    sum_res.bin_power   = best_power_next;
    sum_res.peak_number = peaks_found_next;
    sum_res.final_item  = 1'b1;

    push_a   = is_peak ? peak_res : sum_res;
    push_b   = sum_res;
    push_cnt = go ? (2'(is_peak) + 2'(st_last)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter        <= '0;
      previous_power     <= '0;
      center_power       <= '0;
      last_peak_position <= '0;
      have_peak          <= 1'b0;
      peaks_found        <= '0;
      best_power         <= '0;
      best_bin           <= LOWEST_RST;
    end else if (go) begin
      if (st_last) begin
        bin_counter        <= '0;
        previous_power     <= '0;
        center_power       <= '0;
        last_peak_position <= '0;
        have_peak          <= 1'b0;
        peaks_found        <= '0;
        best_power         <= '0;
        best_bin           <= cfg.lowest_bin;
      end else begin
        if (bin_counter != BIN_MAX) begin
          bin_counter <= bin_counter + BIN_W'(1);
        end
        previous_power <= center_power;
        center_power   <= st_power;
        peaks_found    <= peaks_found_next;
        best_power     <= best_power_next;
        best_bin       <= best_bin_next;
        if (is_peak) begin
          last_peak_position <= center_bin;
          have_peak          <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/spp_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak picker result queue
// Small result queue, bin-to-frequency conversion and output register.
// ----------------------------------------------------------------------------
module spp_outq
  import spp_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic [RATE_W-1:0] sample_rate_hz,
  input  logic [1:0]        push_cnt,
  input  res_t              push_a,
  input  res_t              push_b,
  output logic              room,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [71:0]       m_tdata,   // bin_index, bin_hz, bin_power, peak_number
  output logic              m_tuser,   // kind
  output logic              m_tlast
);

  localparam int LOG2N = $clog2(FFT_POINTS);
  localparam int HALF  = FFT_POINTS / 2;
  localparam int PROD_W = BIN_W + RATE_W;

  res_t               q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               pop;
  res_t               head;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    rounded;
  logic [PROD_W:0]    shifted;
  logic [FREQ_W-1:0]  freq;

  logic               out_kind;
  logic [BIN_W-1:0]   out_bin;
  logic [FREQ_W-1:0]  out_freq;
  logic [POWER_W-1:0] out_power;
  logic [PEAK_W-1:0]  out_num;
  logic               out_final;

  assign room = count < QCNT_W'(QUEUE_DEPTH - 1);
  assign pop  = (count != '0) && (!m_tvalid || m_tready);
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((push_cnt != 2'd0) && (wr_ptr == QPTR_W'(i))) begin
        q[i] <= push_a;
      end
      if ((push_cnt == 2'd2) && ((wr_ptr + QPTR_W'(1)) == QPTR_W'(i))) begin
        q[i] <= push_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_cnt);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end
  end

  always_comb begin
    prod    = PROD_W'(head.bin_index) * PROD_W'(sample_rate_hz);
    rounded = {1'b0, prod} + (PROD_W + 1)'(HALF);
    shifted = rounded >> LOG2N;
    freq    = (shifted > (PROD_W + 1)'(FREQ_MAX)) ? FREQ_MAX : shifted[FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind  <= head.kind;
      out_bin   <= head.bin_index;
      out_freq  <= freq;
      out_power <= head.bin_power;
      out_num   <= head.peak_number;
      out_final <= head.final_item;
    end
  end

  assign m_tdata = {2'b00, out_num, out_power, out_freq, out_bin};
  assign m_tuser = out_kind;
  assign m_tlast = out_final;

endmodule

// ===== hw/rtl/spectral_peak_picker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak picker
// Local-maximum peak detection over a streamed power spectrum.
// ----------------------------------------------------------------------------
// Power bins enter on the slave stream from bin 0 upward, one bin per transfer;
// tdata carries the 32-bit power and tlast marks the final bin of a spectrum.
// Each local peak in the search window that meets the spacing and peak limit
// leaves on the master stream as one transfer with tuser low; after the final bin
// a summary transfer, tuser and tlast high, gives the strongest bin and peak count.
// The block takes one bin per cycle while the result queue has room. A result
// passes the result queue and the output register before it is valid; a summary
// that follows a peak from the same bin is the next transfer after that peak.
// The input side stalls only while the four-entry result queue cannot take
// two more results, so a stalled receiver backs up into the input and nothing
// is dropped.
// Reset clears the spectrum state and loads the register defaults. The APB
// registers must be written only while no spectrum is in progress.
// ----------------------------------------------------------------------------
module spectral_peak_picker_top
  import spp_pkg::*;
#(
  parameter int FFT_POINTS = FFT_POINTS_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [POWER_W-1:0] s_tdata,   // power[31:0]
  input  logic               s_tlast,   // last_bin
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [71:0]        m_tdata,   // bin_index, bin_hz, bin_power, peak_number
  output logic               m_tuser,   // kind
  output logic               m_tlast,   // final_item
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t       cfg;
  logic       room;
  logic [1:0] push_cnt;
  res_t       push_a;
  res_t       push_b;

  spp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spp_detect #(
    .FFT_POINTS (FFT_POINTS)
  ) u_detect (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .room     (room),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (push_b)
  );

  spp_outq #(
    .FFT_POINTS (FFT_POINTS)
  ) u_outq (
    .clk            (clk),
    .rst            (rst),
    .sample_rate_hz (cfg.sample_rate_hz),
    .push_cnt       (push_cnt),
    .push_a         (push_a),
    .push_b         (push_b),
    .room           (room),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

endmodule
